// ===== design/ip_address_text_validator_assert.svh =====
// Assertion macros for the address text validator.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the including scope.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IATV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("address validator check failed");

// Next-cycle implication, checked outside reset.
`define IATV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("address validator check failed");

`endif

// ===== design/iatv_pkg.sv =====
// Shared types, codes and helpers for the address text validator.
// No dependencies.
package iatv_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2
    } t_sep_kind;

    localparam logic [1:0] VERDICT_V4      = 2'd0;
    localparam logic [1:0] VERDICT_V6      = 2'd1;
    localparam logic [1:0] VERDICT_NEITHER = 2'd2;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [2:0] LEN_SAT    = 3'd5;
    localparam logic [8:0] VALUE_SAT  = 9'd256;
    localparam logic [8:0] VALUE_MAX  = 9'd255;
    localparam logic [3:0] COUNT_SAT  = 4'd9;
    localparam logic [3:0] COUNT_V4   = 4'd4;
    localparam logic [3:0] COUNT_V6   = 4'd8;
    localparam logic [2:0] LEN_MAX_V4 = 3'd3;
    localparam logic [2:0] LEN_MAX_V6 = 3'd4;

    typedef struct packed {
        logic [2:0] len;
        logic [8:0] value;
        logic       lead_zero;
        logic       all_dec;
        logic       all_hex;
    } t_group;

    localparam t_group GROUP_CLEAR = '{len: 3'd0, value: 9'd0, lead_zero: 1'b0,
                                       all_dec: 1'b1, all_hex: 1'b1};

    // True when the group meets the rule of the given kind.
    function automatic logic group_ok(input t_sep_kind kind, input t_group g);
        logic ok;
        ok = 1'b0;
        unique case (kind)
            KIND_V4: ok = (g.len != 3'd0) && (g.len <= LEN_MAX_V4) && g.all_dec &&
                          (g.value <= VALUE_MAX) && !(g.lead_zero && (g.len > 3'd1));
            KIND_V6: ok = (g.len != 3'd0) && (g.len <= LEN_MAX_V6) && g.all_hex;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== design/ip_address_text_validator.sv =====
// Top level of the IPv4 / IPv6 address text validator.
// Input register, group check, result register. Depends on iatv_pkg and
// ip_address_text_validator_assert.svh.
//
//  channel  | dir | tdata (low bit up)          | tuser | tlast
//  ---------+-----+-----------------------------+-------+-----------------
//  s_axis   | in  | [7:0] character             | none  | last_char
//  m_axis   | out | [1:0] verdict, [7:2] zero   | none  | none
//
// One character is taken every cycle while m_axis is not stalled; the group check sits
// between the input register and the result register, so a verdict passes through the
// input register and then the result register before it is valid on m_axis.
// Reset (synchronous, active low) clears valids and the string state.
// A stall on m_axis holds the result register and the input register; s_axis
// keeps taking one more character until the input register fills.
`include "ip_address_text_validator_assert.svh"

module ip_address_text_validator
    import iatv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] character
    input  logic       i_s_axis_tlast,   // last_char
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] verdict, [7:2] zero
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // string state
    t_sep_kind  r_kind,  n_kind;
    t_group     r_group, n_group;
    logic [3:0] r_count, n_count;
    logic       r_failed, n_failed;

    // result register
    logic       r_out_valid;
    logic [1:0] r_verdict, n_verdict;

    logic advance;
    logic consume;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign consume         = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    // Hold a character until the check stage can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Character classes and the group as it stands after this character.
    logic        is_dot, is_colon, is_sep, is_dec, is_hex;
    t_sep_kind   char_kind, sep_kind;
    t_group      grown;
    logic [12:0] value_wide;
    logic [3:0]  count_inc;
    logic        end_ok;

    always_comb begin
        is_dot   = (r_in_char == CHAR_DOT);
        is_colon = (r_in_char == CHAR_COLON);
        is_sep   = is_dot || is_colon;
        is_dec   = (r_in_char >= 8'h30) && (r_in_char <= 8'h39);
        is_hex   = is_dec || ((r_in_char >= 8'h61) && (r_in_char <= 8'h66)) ||
                   ((r_in_char >= 8'h41) && (r_in_char <= 8'h46));
        char_kind = is_dot ? KIND_V4 : KIND_V6;
        sep_kind  = (r_kind == KIND_NONE) ? char_kind : r_kind;

        // Append the character to the current group.
        value_wide = {1'b0, r_group.value, 3'b000} + {3'b000, r_group.value, 1'b0} +
                     {9'd0, r_in_char[3:0]};
        grown = r_group;
        if ((r_group.len == 3'd0) && (r_in_char == CHAR_ZERO)) begin
            grown.lead_zero = 1'b1;
        end
        if (r_group.len < LEN_SAT) begin
            grown.len = r_group.len + 3'd1;
        end
        if (!is_dec) begin
            grown.all_dec = 1'b0;
        end
        if (!is_hex) begin
            grown.all_hex = 1'b0;
        end
        if (is_dec) begin
            grown.value = (value_wide > {4'd0, VALUE_SAT}) ? VALUE_SAT : value_wide[8:0];
        end

        count_inc = (r_count < COUNT_SAT) ? (r_count + 4'd1) : r_count;
        end_ok    = is_sep ? group_ok(sep_kind, r_group) : group_ok(r_kind, grown);
    end

    // Next string state and verdict.
    always_comb begin
        n_kind    = r_kind;
        n_group   = r_group;
        n_count   = r_count;
        n_failed  = r_failed;
        n_verdict = VERDICT_NEITHER;
        if (is_sep) begin
            // Close the group under the kind fixed by the first separator.
            n_kind   = sep_kind;
            n_failed = r_failed || ((r_kind != KIND_NONE) && (r_kind != char_kind)) || !end_ok;
            n_count  = count_inc;
            n_group  = GROUP_CLEAR;
        end else begin
            n_group = grown;
            if ((r_kind != KIND_NONE) && r_failed == 1'b0 && end_ok) begin
                if ((r_kind == KIND_V4) && (count_inc == COUNT_V4)) begin
                    n_verdict = VERDICT_V4;
                end else if ((r_kind == KIND_V6) && (count_inc == COUNT_V6)) begin
                    n_verdict = VERDICT_V6;
                end
            end
        end
        // Drop back to the empty string after the last character.
        if (r_in_last) begin
            n_kind   = KIND_NONE;
            n_group  = GROUP_CLEAR;
            n_count  = 4'd0;
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_NONE;
            r_group  <= GROUP_CLEAR;
            r_count  <= 4'd0;
            r_failed <= 1'b0;
        end else if (consume) begin
            r_kind   <= n_kind;
            r_group  <= n_group;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

    // Result register: load a verdict on the last character, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= consume && r_in_last;
        end
        if (consume && r_in_last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_verdict};

    // The last character of a string always yields a verdict next cycle.
    `IATV_ASSERT_NEXT(a_last_gives_verdict, consume && r_in_last, o_m_axis_tvalid)
    // The state is back at reset after the last character.
    `IATV_ASSERT_NEXT(a_last_clears_state, consume && r_in_last,
                      (r_kind == KIND_NONE) && (r_count == 4'd0) && !r_failed)
    // A shown verdict is one of the three codes.
    `IATV_ASSERT_NOW(a_verdict_code, o_m_axis_tvalid,
                     (r_verdict == VERDICT_V4) || (r_verdict == VERDICT_V6) ||
                     (r_verdict == VERDICT_NEITHER))

endmodule

// ===== tb/ip_address_text_validator_check.sv =====
// Scoreboard for the address text validator: watches both stream channels and
// predicts one verdict per string from the character transfers.
// Depends on iatv_pkg for the group record, kind codes and verdict codes.
`timescale 1ns / 100ps

module ip_address_text_validator_check
    import iatv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] character
    input  logic       i_s_tlast,    // last_char
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [1:0] verdict, [7:2] zero
    output int         o_errors,
    output int         o_pending
);

    t_sep_kind  str_kind;
    t_group     grp;
    logic [3:0] groups_closed;
    logic       str_broken;
    logic [1:0] pending_verdicts[$];

    // Group rule for a kind; an unknown kind never passes.
    function automatic logic group_passes(input t_sep_kind k, input t_group g);
        if (g.len == 3'd0) return 1'b0;
        if (k == KIND_V4) begin
            if (g.len > LEN_MAX_V4 || !g.all_dec || g.value > VALUE_MAX) return 1'b0;
            return !(g.lead_zero && g.len != 3'd1);
        end
        if (k == KIND_V6) return (g.len <= LEN_MAX_V6) && g.all_hex;
        return 1'b0;
    endfunction

    task automatic close_group(input t_sep_kind k);
        if (!group_passes(k, grp)) str_broken = 1'b1;
        if (groups_closed < COUNT_SAT) groups_closed = groups_closed + 4'd1;
        grp = GROUP_CLEAR;
    endtask

    task automatic restart_string();
        str_kind      = KIND_NONE;
        groups_closed = 4'd0;
        str_broken    = 1'b0;
        grp           = GROUP_CLEAR;
    endtask

    // Fold one transferred character into the string state; queue a verdict on the last one.
    task automatic absorb_char(input logic [7:0] c, input logic last);
        t_sep_kind   k;
        logic        is_dec;
        logic        is_hex;
        int unsigned v;
        logic [1:0]  verdict;
        if (c == CHAR_DOT || c == CHAR_COLON) begin
            k = (c == CHAR_DOT) ? KIND_V4 : KIND_V6;
            if (str_kind == KIND_NONE) str_kind = k;
            else if (str_kind != k) str_broken = 1'b1;
            close_group(str_kind);
            if (last) begin
                // a separator can never end a good address
                pending_verdicts.push_back(VERDICT_NEITHER);
                restart_string();
            end
        end else begin
            is_dec = (c >= CHAR_ZERO) && (c <= "9");
            is_hex = is_dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            if (grp.len == 3'd0 && c == CHAR_ZERO) grp.lead_zero = 1'b1;
            if (grp.len < LEN_SAT) grp.len = grp.len + 3'd1;
            if (!is_dec) grp.all_dec = 1'b0;
            if (!is_hex) grp.all_hex = 1'b0;
            if (is_dec) begin
                v = grp.value * 10 + (c - CHAR_ZERO);
                grp.value = (v > VALUE_SAT) ? VALUE_SAT : v[8:0];
            end
            if (last) begin
                verdict = VERDICT_NEITHER;
                if (str_kind != KIND_NONE) begin
                    close_group(str_kind);
                    if (!str_broken && str_kind == KIND_V4 && groups_closed == COUNT_V4)
                        verdict = VERDICT_V4;
                    else if (!str_broken && str_kind == KIND_V6 && groups_closed == COUNT_V6)
                        verdict = VERDICT_V6;
                end
                pending_verdicts.push_back(verdict);
                restart_string();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [1:0] want);
        $display("%0t: verdict mismatch, %s: tdata %h, expected verdict %0d",
                 $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        logic [1:0] want;
        if (!i_rst_n) begin
            restart_string();
            pending_verdicts.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected transfer", i_m_tdata, VERDICT_NEITHER);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_m_tdata[1:0] != want)
                        report_mismatch("wrong verdict", i_m_tdata, want);
                    if (i_m_tdata[7:2] != 6'd0)
                        report_mismatch("nonzero pad bits", i_m_tdata, want);
                end
            end
            if (i_s_tvalid && i_s_tready) absorb_char(i_s_tdata, i_s_tlast);
        end
        o_pending = pending_verdicts.size();
    end

endmodule

// ===== tb/ip_address_text_validator_test.sv =====
// Stimulus top for the address text validator: drives address strings through the
// block under several idling patterns and gives the final verdict.
// Depends on iatv_pkg, ip_address_text_validator and ip_address_text_validator_check.
`timescale 1ns / 100ps

module ip_address_text_validator_test;
    import iatv_pkg::*;

    localparam int CHARS_PER_PHASE = 350;     // four phases, about 1400 characters
    localparam int DRAIN_CYCLES    = 8;       // verdict passes the input and result registers after its last char
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] character
    logic       s_tlast;    // last_char
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [1:0] verdict, [7:2] zero

    int          errors;
    int          pending;
    int          cycle_count;
    int unsigned sent_chars;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic [7:0]  text_q[$];

    ip_address_text_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    ip_address_text_validator_check verdict_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Bail out if the run hangs; a correct run finishes long before this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver side: one tready decision per falling edge, at the phase's stall rate.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] pick_hex();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'(CHAR_ZERO + k);
        if (k < 16) return 8'("a" + (k - 10));
        return 8'("A" + (k - 16));
    endfunction

    // Append a decimal value without leading zeros.
    task automatic add_decimal(input int unsigned v);
        if (v >= 100) text_q.push_back(8'(CHAR_ZERO + v / 100));
        if (v >= 10) text_q.push_back(8'(CHAR_ZERO + (v / 10) % 10));
        text_q.push_back(8'(CHAR_ZERO + v % 10));
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Mostly legal dotted groups; the rest are empty, zero-led, too large, too long or end in a hex or random byte.
    task automatic add_v4_group();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            add_decimal($urandom_range(0, 255));
        end else if (r < 82) begin
            // empty group
        end else if (r < 87) begin
            text_q.push_back(CHAR_ZERO);
            add_decimal($urandom_range(0, 99));
        end else if (r < 91) begin
            add_decimal($urandom_range(256, 999));
        end else if (r < 95) begin
            add_decimal($urandom_range(100, 999));
            text_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end else begin
            add_decimal($urandom_range(0, 25));
            text_q.push_back(($urandom_range(0, 1) != 0) ? pick_hex() : 8'($urandom));
        end
    endtask

    // Mostly legal hex groups; the rest are empty, too long or hold a bad or random byte.
    task automatic add_v6_group();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(pick_hex());
        end else if (r < 84) begin
            // empty group
        end else if (r < 91) begin
            repeat ($urandom_range(5, 7)) text_q.push_back(pick_hex());
        end else begin
            repeat ($urandom_range(0, 2)) text_q.push_back(pick_hex());
            text_q.push_back(($urandom_range(0, 1) != 0) ? 8'("g" + $urandom_range(0, 19))
                                                           : 8'($urandom));
            repeat ($urandom_range(0, 1)) text_q.push_back(pick_hex());
        end
    endtask

    // Build one string: mostly addresses of either kind with random content, some noise.
    task automatic add_address();
        int unsigned r;
        int unsigned n_groups;
        logic        v6;
        logic [7:0]  own_sep;
        logic [7:0]  other_sep;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(8'($urandom));
                    1: text_q.push_back(CHAR_DOT);
                    2: text_q.push_back(CHAR_COLON);
                    default: text_q.push_back(pick_hex());
                endcase
            end
        end else begin
            v6        = (r >= 56);
            own_sep   = v6 ? CHAR_COLON : CHAR_DOT;
            other_sep = v6 ? CHAR_DOT : CHAR_COLON;
            // mostly the right group count; otherwise anything up to past saturation
            n_groups = ($urandom_range(0, 99) < 75) ? (v6 ? 8 : 4) : $urandom_range(1, 11);
            for (int i = 0; i < n_groups; i++) begin
                if (i > 0) text_q.push_back(($urandom_range(0, 49) == 0) ? other_sep : own_sep);
                if (v6) add_v6_group();
                else add_v4_group();
            end
            if ($urandom_range(0, 19) == 0) text_q.push_back(own_sep);
        end
        // every string needs a last character
        if (text_q.size() == 0) text_q.push_back(pick_hex());
    endtask

    // Present one character at the falling edge and hold it until the transfer.
    task automatic drive_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Send the assembled string, marking its final byte with tlast, then drop it.
    task automatic drive_text();
        for (int i = 0; i < text_q.size(); i++)
            drive_char(text_q[i], i == text_q.size() - 1);
        sent_chars += text_q.size();
        text_q.delete();
    endtask

    // Hold the sender until every verdict sent so far has come back.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        s_tlast        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_chars     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed strings: no separator, lone trailing separator, mixed kinds,
        // high and zero bytes, largest legal dotted value, legal hex in both cases.
        add_string("7");
        drive_text();
        add_string(":");
        drive_text();
        add_string("1:.2");
        drive_text();
        text_q.push_back(8'hFF);
        text_q.push_back(CHAR_DOT);
        text_q.push_back(8'h00);
        drive_text();
        add_string("255.0.9.1");
        drive_text();
        add_string("a:B:0:9:f:F:1:2");
        drive_text();

        // Random strings, one idling pattern per phase: none, slow sender,
        // slow receiver, both lightly; drain between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            while (sent_chars < (phase + 1) * CHARS_PER_PHASE) begin
                add_address();
                drive_text();
            end
            drain_verdicts();
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
